[rtl/core/bb3_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants of the 3x3 box blur
// Transfer formats, register indexes, fixed widths and the reciprocal table
// used to turn the rounded mean into a multiply and shift.
// ----------------------------------------------------------------------------
package bb3_pkg;

	localparam int CFG_W          = 11;
	localparam int CFG_IDX_W      = 1;
	localparam int CH_W           = 8;
	localparam int PIX_W          = 3 * CH_W;
	localparam int SUM_W          = 12;
	localparam int CNT_W          = 4;
	localparam int RECIP_W        = 24;
	localparam int RECIP_SHIFT    = 24;
	localparam int DIM_MIN        = 2;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int OFIFO_DEPTH    = 4;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	typedef struct packed {
		logic            req_type;
		logic [CH_W-1:0] in_red;
		logic [CH_W-1:0] in_green;
		logic [CH_W-1:0] in_blue;
	} req_t;

	typedef struct packed {
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic            frame_end;
	} res_t;

	// Ceiling of 2^24 / (2 * n) for every neighbour count that can occur.
	function automatic logic [RECIP_W-1:0] bb3_recip(input logic [CNT_W-1:0] n);
		logic [RECIP_W-1:0] m;
		unique case (n)
			4'd1:    m = 24'd8388608;
			4'd2:    m = 24'd4194304;
			4'd3:    m = 24'd2796203;
			4'd4:    m = 24'd2097152;
			4'd6:    m = 24'd1398102;
			4'd9:    m = 24'd932068;
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

[rtl/core/bb3_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bb3_ram #(
	parameter int WIDTH = 2 * bb3_pkg::PIX_W,
	parameter int DEPTH = bb3_pkg::MAX_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/core/bb3_ofifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_ofifo: result queue
// Small register queue in front of the result channel. The writer keeps a
// credit count, so a push always finds room.
// ----------------------------------------------------------------------------
module bb3_ofifo #(
	parameter int DEPTH = bb3_pkg::OFIFO_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  bb3_pkg::res_t              push_data,
	output logic                       res_valid,
	input  logic                       res_stall,
	output bb3_pkg::res_t              res,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	bb3_pkg::res_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] cnt_q;
	logic          pop;

	assign res_valid = (cnt_q != '0);
	assign pop       = res_valid && !res_stall;
	assign res       = mem_q[rd_ptr_q];
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + NW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - NW'(1);
			end
		end
	end

endmodule

[rtl/core/box_blur_3x3_edge_clipped_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_clipped_core: streaming 3x3 box blur with edge clipping
// RGB pixels arrive in raster order on the req channel; blurred pixels leave
// in raster order on the res channel. Each channel is the rounded-half-up
// mean of the neighbours that lie inside the image.
//
// Channels: req and res use valid/stall; a transfer happens at a rising edge
// with valid high and stall low. A req item of type pixel carries one pixel;
// once the last pixel of a frame is in, the last image_width + 1 results are
// fetched with one req item each (any type; a drain item with nothing
// outstanding is taken and gives no result).
// Configuration: cfg_we/cfg_index/cfg_data write image_width (index 0) and
// image_height (index 1); values are clamped to [2, MAX_WIDTH/MAX_HEIGHT].
// Results pass the stage 1 and 2 registers and the result queue. Throughput:
// one req item per cycle while req_stall is low, set by the single read and
// write per item of the one line-store RAM (two rows packed side by side).
// Stall: a four-entry result queue absorbs items in flight; req_stall rises
// only when the queue plus the two pipeline stages hold four results.
// Reset: counters, window and queue clear at once; the line store needs no
// clearing pass, and both registers return to 2.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_clipped_core #(
	parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  bb3_pkg::req_t                   req,
	output logic                            res_valid,
	input  logic                            res_stall,
	output bb3_pkg::res_t                   res,
	input  logic                            cfg_we,
	input  logic [bb3_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bb3_pkg::CFG_W-1:0]       cfg_data
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int PDW  = $clog2(MAX_WIDTH + 2);
	localparam int XW0  = (CW > RW) ? CW : RW;
	localparam int XW1  = (XW0 > bb3_pkg::CFG_W) ? XW0 : bb3_pkg::CFG_W;
	localparam int XW   = XW1 + 1;
	localparam int OCW  = $clog2(bb3_pkg::OFIFO_DEPTH + 1);
	localparam int PIXW = bb3_pkg::PIX_W;
	localparam int CHW  = bb3_pkg::CH_W;
	localparam int SW   = bb3_pkg::SUM_W;
	localparam int NW   = bb3_pkg::CNT_W;
	localparam int TW   = SW + 1;
	localparam int MW   = TW + bb3_pkg::RECIP_W;

	localparam logic [XW-1:0] W_MAX   = XW'(MAX_WIDTH);
	localparam logic [XW-1:0] H_MAX   = XW'(MAX_HEIGHT);
	localparam logic [XW-1:0] D_MIN   = XW'(bb3_pkg::DIM_MIN);
	localparam logic [XW-1:0] ONE_X   = XW'(1);
	localparam logic [XW-1:0] TWO_X   = XW'(2);
	localparam logic [XW-1:0] THREE_X = XW'(3);
	localparam logic [CW-1:0] C_LAST  = CW'(MAX_WIDTH - 1);

	// Configuration registers.
	logic [bb3_pkg::CFG_W-1:0] img_w_q;
	logic [bb3_pkg::CFG_W-1:0] img_h_q;
	logic [XW-1:0]             w_x;
	logic [XW-1:0]             h_x;
	logic [XW-1:0]             img_w_x;
	logic [XW-1:0]             img_h_x;

	// Position state.
	logic [CW-1:0]  c_q;
	logic [RW-1:0]  r_q;
	logic [PDW-1:0] pend_q;
	logic [CW-1:0]  c_nx;
	logic [RW-1:0]  r_nx;
	logic [PDW-1:0] pend_nx;
	logic [XW-1:0]  c_x;
	logic [XW-1:0]  r_x;

	// Decode of the accepted item.
	logic            acc;
	logic            shift0;
	logic            res0;
	logic            pre0;
	logic            fend0;
	logic [XW-1:0]   oy0;
	logic [PIXW-1:0] pix0;
	logic [2:0]      rm0;
	logic [2:0]      cm0;

	// Stage 1: line-store read data and window update.
	logic            shift_s1;
	logic            res_s1;
	logic            pre_s1;
	logic            fend_s1;
	logic [2:0]      rm_s1;
	logic [2:0]      cm_s1;
	logic [CW-1:0]   col_s1;
	logic [PIXW-1:0] pix_s1;
	logic            byp_s1;
	logic [2*PIXW-1:0] byp_data_s1;

	logic [2*PIXW-1:0] ram_rd;
	logic [2*PIXW-1:0] ram_wdata;
	logic [PIXW-1:0]   rd_up;
	logic [PIXW-1:0]   rd_mid;

	logic [PIXW-1:0] win_q   [3][3];
	logic [PIXW-1:0] win_nx  [3][3];
	logic [PIXW-1:0] win_sel [3][3];

	logic [SW-1:0] sum_c [3];
	logic [NW-1:0] n_c;

	// Stage 2: rounded mean.
	logic          res_s2;
	logic          fend_s2;
	logic [SW-1:0] sum_s2 [3];
	logic [NW-1:0] n_s2;

	logic [bb3_pkg::RECIP_W-1:0] recip;
	logic [TW-1:0]               t_c  [3];
	logic [MW-1:0]               prod [3];
	logic [CHW-1:0]              q_c  [3];
	bb3_pkg::res_t               res_d;

	logic [OCW-1:0] ocnt;
	logic [OCW:0]   credit;

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= bb3_pkg::CFG_W'(bb3_pkg::DIM_MIN);
			img_h_q <= bb3_pkg::CFG_W'(bb3_pkg::DIM_MIN);
		end else if (cfg_we) begin
			unique case (cfg_index)
				bb3_pkg::REG_IMAGE_WIDTH:  img_w_q <= cfg_data;
				bb3_pkg::REG_IMAGE_HEIGHT: img_h_q <= cfg_data;
			endcase
		end
	end

	assign img_w_x = XW'(img_w_q);
	assign img_h_x = XW'(img_h_q);
	assign w_x = (img_w_x < D_MIN) ? D_MIN : ((img_w_x > W_MAX) ? W_MAX : img_w_x);
	assign h_x = (img_h_x < D_MIN) ? D_MIN : ((img_h_x > H_MAX) ? H_MAX : img_h_x);
	assign c_x = XW'(c_q);
	assign r_x = XW'(r_q);

	assign credit    = (OCW + 1)'(ocnt) + (OCW + 1)'(res_s1) + (OCW + 1)'(res_s2);
	assign req_stall = (credit >= (OCW + 1)'(bb3_pkg::OFIFO_DEPTH));
	assign acc       = req_valid && !req_stall;

	// Item decode and position update.
	always_comb begin
		shift0  = 1'b0;
		res0    = 1'b0;
		pre0    = 1'b0;
		fend0   = 1'b0;
		oy0     = '0;
		pix0    = '0;
		c_nx    = c_q;
		r_nx    = r_q;
		pend_nx = pend_q;
		if (pend_q != '0) begin
			if (pend_q == PDW'(1)) begin
				res0    = 1'b1;
				pre0    = 1'b1;
				fend0   = 1'b1;
				oy0     = h_x - ONE_X;
				c_nx    = '0;
				r_nx    = '0;
				pend_nx = '0;
			end else begin
				shift0  = 1'b1;
				res0    = 1'b1;
				pre0    = (c_q == '0);
				oy0     = (c_q == '0) ? (h_x - TWO_X) : (h_x - ONE_X);
				c_nx    = (c_q < C_LAST) ? (c_q + CW'(1)) : c_q;
				pend_nx = pend_q - PDW'(1);
			end
		end else if (req.req_type == bb3_pkg::REQ_PIXEL) begin
			shift0 = 1'b1;
			pix0   = {req.in_red, req.in_green, req.in_blue};
			if (c_q == '0 && r_x >= TWO_X) begin
				res0 = 1'b1;
				pre0 = 1'b1;
				oy0  = r_x - TWO_X;
			end else if (c_q != '0 && r_x >= ONE_X) begin
				res0 = 1'b1;
				oy0  = r_x - ONE_X;
			end
			if (c_x >= w_x - ONE_X) begin
				c_nx = '0;
				if (r_x >= h_x - ONE_X) begin
					r_nx    = '0;
					pend_nx = PDW'(w_x + ONE_X);
				end else begin
					r_nx = r_q + RW'(1);
				end
			end else begin
				c_nx = c_q + CW'(1);
			end
		end
	end

	// Neighbour rows and columns that lie inside the image.
	always_comb begin
		rm0[0] = (oy0 != '0) && (oy0 <= h_x);
		rm0[1] = (oy0 < h_x);
		rm0[2] = (oy0 + ONE_X < h_x);
		if (pre0) begin
			cm0 = {1'b1, 1'b1, (w_x >= THREE_X)};
		end else begin
			cm0[0] = (c_x >= TWO_X) && (c_x < w_x + TWO_X);
			cm0[1] = (c_x < w_x + ONE_X);
			cm0[2] = (c_x < w_x);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q    <= '0;
			r_q    <= '0;
			pend_q <= '0;
		end else if (acc) begin
			c_q    <= c_nx;
			r_q    <= r_nx;
			pend_q <= pend_nx;
		end
	end

	// Both row stores share one RAM: upper row in the high half.
	bb3_ram #(
		.WIDTH (2 * PIXW),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (shift_s1),
		.waddr (col_s1),
		.wdata (ram_wdata),
		.re    (acc && shift0),
		.raddr (c_q),
		.rdata (ram_rd)
	);

	assign rd_up     = byp_s1 ? byp_data_s1[2*PIXW-1:PIXW] : ram_rd[2*PIXW-1:PIXW];
	assign rd_mid    = byp_s1 ? byp_data_s1[PIXW-1:0] : ram_rd[PIXW-1:0];
	assign ram_wdata = {rd_mid, pix_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_s1 <= 1'b0;
			res_s1   <= 1'b0;
			byp_s1   <= 1'b0;
		end else begin
			shift_s1 <= acc && shift0;
			res_s1   <= acc && res0;
			byp_s1   <= acc && shift0 && shift_s1 && (col_s1 == c_q);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pre_s1      <= pre0;
			fend_s1     <= fend0;
			rm_s1       <= rm0;
			cm_s1       <= cm0;
			col_s1      <= c_q;
			pix_s1      <= pix0;
			byp_data_s1 <= ram_wdata;
		end
	end

	// Window shift and masked sums.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			win_nx[i][0] = win_q[i][1];
			win_nx[i][1] = win_q[i][2];
		end
		win_nx[0][2] = rd_up;
		win_nx[1][2] = rd_mid;
		win_nx[2][2] = pix_s1;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				win_sel[i][j] = pre_s1 ? win_q[i][j] : win_nx[i][j];
			end
		end
	end

	always_comb begin
		n_c = '0;
		for (int ch = 0; ch < 3; ch++) begin
			sum_c[ch] = '0;
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (rm_s1[i] && cm_s1[j]) begin
					n_c = n_c + NW'(1);
					for (int ch = 0; ch < 3; ch++) begin
						sum_c[ch] = sum_c[ch] + SW'(win_sel[i][j][(2 - ch) * CHW +: CHW]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (shift_s1) begin
			win_q <= win_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s2 <= 1'b0;
		end else begin
			res_s2 <= res_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_s1) begin
			fend_s2 <= fend_s1;
			n_s2    <= n_c;
			sum_s2  <= sum_c;
		end
	end

	// Rounded mean: (2*sum + n) / (2*n) by reciprocal multiply.
	assign recip = bb3_pkg::bb3_recip(n_s2);

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			t_c[ch]  = {sum_s2[ch], 1'b0} + TW'(n_s2);
			prod[ch] = MW'(t_c[ch]) * MW'(recip);
			q_c[ch]  = prod[ch][bb3_pkg::RECIP_SHIFT +: CHW];
		end
		res_d.out_red   = q_c[0];
		res_d.out_green = q_c[1];
		res_d.out_blue  = q_c[2];
		res_d.frame_end = fend_s2;
	end

	bb3_ofifo #(
		.DEPTH (bb3_pkg::OFIFO_DEPTH)
	) u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_s2),
		.push_data (res_d),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.count     (ocnt)
	);

	a_drain_row: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q != '0) |-> (r_q == '0))
		else $error("row position not cleared while draining");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_s2 |-> (ocnt < OCW'(bb3_pkg::OFIFO_DEPTH)))
		else $error("result pushed into a full queue");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res_s1 && fend_s1) |-> (pend_q == '0 && c_q == '0 && r_q == '0))
		else $error("frame end without return to the first position");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		shift_s1 |-> (col_s1 <= C_LAST))
		else $error("column position beyond the line store");

endmodule
